FILE: rtl/core/e2r_pkg.sv
package e2r_pkg;

   // field widths
   localparam int unsigned SECS_W = 38;
   localparam int unsigned CHAR_W = 7;

   // last second of year 9999
   localparam logic [SECS_W-1:0] MAX_SECONDS = 38'd253402300799;

   // calendar constants
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [21:0] EPOCH_SHIFT   = 22'd719468;
   localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
   localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
   localparam logic [13:0] YEARS_PER_ERA = 14'd400;
   localparam logic [13:0] YEARS_PER_CENT = 14'd100;
   localparam logic [10:0] SECS_PER_MIN  = 11'd60;

   // reciprocals: floor(n / d) == (n * m) >> k, with k = input bits + clog2(d)
   localparam logic [31:0] RCP_DAY  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
   localparam logic [22:0] RCP_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [17:0] RCP_MIN  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
   localparam logic [11:0] RCP_HOUR = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
   localparam logic [18:0] RCP_QUAD = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RCP_YEAR = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [14:0] RCP_CENT = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
   localparam logic [7:0]  RCP_TEN  = 8'(((64'd1 << 11) + 64'd9) / 64'd10);

   // queue between front and back, depth a power of two
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ascii codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;

   // first day of each month in a march-based year
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   // three-letter month names, january first
   localparam logic [CHAR_W-1:0] MONTH_TEXT [12][3] = '{
      '{7'h4A, 7'h61, 7'h6E}, '{7'h46, 7'h65, 7'h62}, '{7'h4D, 7'h61, 7'h72},
      '{7'h41, 7'h70, 7'h72}, '{7'h4D, 7'h61, 7'h79}, '{7'h4A, 7'h75, 7'h6E},
      '{7'h4A, 7'h75, 7'h6C}, '{7'h41, 7'h75, 7'h67}, '{7'h53, 7'h65, 7'h70},
      '{7'h4F, 7'h63, 7'h74}, '{7'h4E, 7'h6F, 7'h76}, '{7'h44, 7'h65, 7'h63}
   };

   // one decoded date, ready for text output
   typedef struct packed {
      logic       range_err;
      logic [1:0] day_tens;
      logic [3:0] day_ones;
      logic [3:0] month;
      logic [3:0] cent_tens;
      logic [3:0] cent_ones;
      logic [3:0] yr_tens;
      logic [3:0] yr_ones;
      logic [3:0] hr_tens;
      logic [3:0] hr_ones;
      logic [3:0] min_tens;
      logic [3:0] min_ones;
      logic [3:0] sec_tens;
      logic [3:0] sec_ones;
   } e2r_entry_type;

   // tens and ones of a value below 128
   function automatic logic [7:0] split_digits(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(value) * 15'(RCP_TEN);
      tens = prod[14:11];
      ones = 7'(value - ({3'd0, tens} << 3) - ({3'd0, tens} << 1));
      return {tens, ones[3:0]};
   endfunction

   // digit to ascii
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit);
      return 7'(CH_ZERO + 7'(digit));
   endfunction

   // one letter of a month name
   function automatic logic [CHAR_W-1:0] month_char(input logic [3:0] month,
                                                     input logic [1:0] idx);
      logic [CHAR_W-1:0] ch;
      ch = CH_SPACE;
      if (month < 4'd12 && idx < 2'd3) begin
         ch = MONTH_TEXT[month][idx];
      end
      return ch;
   endfunction

endpackage

FILE: rtl/core/e2r_front.sv
module e2r_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [37:0]            req_unix_seconds,
   input  logic                   pop,
   output logic                   push_valid,
   output e2r_pkg::e2r_entry_type push_entry
);
   import e2r_pkg::*;

   localparam int unsigned NUM_STAGES = 12;

   logic                  accept;
   logic [QCNT_W-1:0]     credit_ff, credit_in;
   logic [NUM_STAGES-1:0] vld_ff;

   // stage registers
   logic [SECS_W-1:0] s1_secs_ff;
   logic [SECS_W-1:0] s2_secs_ff;
   logic [21:0]       s2_days_ff;
   logic              s2_err_ff;
   logic [16:0]       s3_sod_ff;
   logic [21:0]       s3_z_ff;
   logic              s3_err_ff;
   logic [16:0]       s4_sod_ff;
   logic [21:0]       s4_z_ff;
   logic [4:0]        s4_era_ff;
   logic [10:0]       s4_min_ff;
   logic              s4_err_ff;
   logic [17:0]       s5_doe_ff;
   logic [4:0]        s5_era_ff;
   logic [10:0]       s5_min_ff;
   logic [4:0]        s5_hh_ff;
   logic [5:0]        s5_ss_ff;
   logic              s5_err_ff;
   logic [17:0]       s6_doe_ff;
   logic [17:0]       s6_t_ff;
   logic [4:0]        s6_era_ff;
   logic [4:0]        s6_hh_ff;
   logic [5:0]        s6_mm_ff;
   logic [5:0]        s6_ss_ff;
   logic              s6_err_ff;
   logic [17:0]       s7_doe_ff;
   logic [8:0]        s7_yoe_ff;
   logic [4:0]        s7_era_ff;
   logic [4:0]        s7_hh_ff;
   logic [5:0]        s7_mm_ff;
   logic [5:0]        s7_ss_ff;
   logic              s7_err_ff;
   logic [8:0]        s8_doy_ff;
   logic [13:0]       s8_ybase_ff;
   logic [4:0]        s8_hh_ff;
   logic [5:0]        s8_mm_ff;
   logic [5:0]        s8_ss_ff;
   logic              s8_err_ff;
   logic [13:0]       s9_year_ff;
   logic [4:0]        s9_day_ff;
   logic [3:0]        s9_month_ff;
   logic [4:0]        s9_hh_ff;
   logic [5:0]        s9_mm_ff;
   logic [5:0]        s9_ss_ff;
   logic              s9_err_ff;
   logic [13:0]       s10_year_ff;
   logic [6:0]        s10_cent_ff;
   logic [4:0]        s10_day_ff;
   logic [3:0]        s10_month_ff;
   logic [4:0]        s10_hh_ff;
   logic [5:0]        s10_mm_ff;
   logic [5:0]        s10_ss_ff;
   logic              s10_err_ff;
   logic [6:0]        s11_cent_ff;
   logic [6:0]        s11_yy_ff;
   logic [4:0]        s11_day_ff;
   logic [3:0]        s11_month_ff;
   logic [4:0]        s11_hh_ff;
   logic [5:0]        s11_mm_ff;
   logic [5:0]        s11_ss_ff;
   logic              s11_err_ff;
   e2r_entry_type     s12_entry_ff;

   // combinational results of each stage
   logic [62:0] day_prod;
   logic [38:0] sod_full;
   logic [44:0] era_prod;
   logic [34:0] min_prod;
   logic [21:0] doe_full;
   logic [16:0] ss_full;
   logic [22:0] hour_prod;
   logic [36:0] quad_prod;
   logic [2:0]  cent_days;
   logic        era_end;
   logic [18:0] t_full;
   logic [10:0] mm_full;
   logic [36:0] yoe_prod;
   logic [2:0]  yoe_cent;
   logic [17:0] doy_full;
   logic [3:0]  mp;
   logic [8:0]  day_full;
   logic [28:0] cent_prod;
   logic [13:0] yy_full;
   logic [7:0]  day_dig, cent_dig, yy_dig, hh_dig, mm_dig, ss_dig;

   // credit: items in the pipeline plus the queue never exceed its depth
   assign req_stall = reset || (credit_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign credit_in = QCNT_W'(credit_ff + QCNT_W'(accept) - QCNT_W'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         vld_ff    <= '0;
      end else begin
         credit_ff <= credit_in;
         vld_ff    <= {vld_ff[NUM_STAGES-2:0], accept};
      end
   end

   // split seconds into days and seconds of the day
   assign day_prod = 63'(s1_secs_ff[37:7]) * 63'(RCP_DAY);
   assign sod_full = 39'(s2_secs_ff) - 39'(s2_days_ff) * 39'(SECS_PER_DAY);

   // era and minutes
   assign era_prod = 45'(s3_z_ff) * 45'(RCP_ERA);
   assign min_prod = 35'(s3_sod_ff) * 35'(RCP_MIN);

   // day of era, seconds, hours
   assign doe_full  = s4_z_ff - 22'(s4_era_ff) * 22'(DAYS_PER_ERA);
   assign ss_full   = s4_sod_ff - 17'(s4_min_ff) * 17'(SECS_PER_MIN);
   assign hour_prod = 23'(s4_min_ff) * 23'(RCP_HOUR);

   // leap-day correction and minutes
   assign quad_prod = 37'(s5_doe_ff) * 37'(RCP_QUAD);
   assign cent_days = 3'(s5_doe_ff >= 18'd36524) + 3'(s5_doe_ff >= 18'd73048)
                    + 3'(s5_doe_ff >= 18'd109572) + 3'(s5_doe_ff >= 18'd146096);
   assign era_end   = (s5_doe_ff >= 18'd146096);
   assign t_full    = 19'(s5_doe_ff) - 19'(quad_prod[36:29]) + 19'(cent_days)
                    - 19'(era_end);
   assign mm_full   = s5_min_ff - 11'(s5_hh_ff) * SECS_PER_MIN;

   // year of era
   assign yoe_prod = 37'(s6_t_ff) * 37'(RCP_YEAR);

   // day of year
   assign yoe_cent = 3'(s7_yoe_ff >= 9'd100) + 3'(s7_yoe_ff >= 9'd200)
                   + 3'(s7_yoe_ff >= 9'd300) + 3'(s7_yoe_ff >= 9'd400)
                   + 3'(s7_yoe_ff >= 9'd500);
   assign doy_full = s7_doe_ff - (18'(s7_yoe_ff) * DAYS_PER_YEAR
                   + 18'(s7_yoe_ff[8:2]) - 18'(yoe_cent));

   // month from day of year
   always_comb begin
      mp = '0;
      for (int i = 1; i < 12; i++) begin
         mp = mp + 4'(s8_doy_ff >= MONTH_START[i]);
      end
   end
   assign day_full = s8_doy_ff - MONTH_START[mp] + 9'd1;

   // century and two-digit year
   assign cent_prod = 29'(s9_year_ff) * 29'(RCP_CENT);
   assign yy_full   = s10_year_ff - 14'(s10_cent_ff) * YEARS_PER_CENT;

   // decimal digits
   assign day_dig  = split_digits(7'(s11_day_ff));
   assign cent_dig = split_digits(s11_cent_ff);
   assign yy_dig   = split_digits(s11_yy_ff);
   assign hh_dig   = split_digits(7'(s11_hh_ff));
   assign mm_dig   = split_digits(7'(s11_mm_ff));
   assign ss_dig   = split_digits(7'(s11_ss_ff));

   // datapath registers
   always_ff @(posedge clock) begin
      s1_secs_ff <= req_unix_seconds;

      s2_secs_ff <= s1_secs_ff;
      s2_days_ff <= day_prod[62:41];
      s2_err_ff  <= (s1_secs_ff > MAX_SECONDS);

      s3_sod_ff <= sod_full[16:0];
      s3_z_ff   <= s2_days_ff + EPOCH_SHIFT;
      s3_err_ff <= s2_err_ff;

      s4_sod_ff <= s3_sod_ff;
      s4_z_ff   <= s3_z_ff;
      s4_era_ff <= era_prod[44:40];
      s4_min_ff <= min_prod[33:23];
      s4_err_ff <= s3_err_ff;

      s5_doe_ff <= doe_full[17:0];
      s5_era_ff <= s4_era_ff;
      s5_min_ff <= s4_min_ff;
      s5_hh_ff  <= hour_prod[21:17];
      s5_ss_ff  <= ss_full[5:0];
      s5_err_ff <= s4_err_ff;

      s6_doe_ff <= s5_doe_ff;
      s6_t_ff   <= t_full[17:0];
      s6_era_ff <= s5_era_ff;
      s6_hh_ff  <= s5_hh_ff;
      s6_mm_ff  <= mm_full[5:0];
      s6_ss_ff  <= s5_ss_ff;
      s6_err_ff <= s5_err_ff;

      s7_doe_ff <= s6_doe_ff;
      s7_yoe_ff <= yoe_prod[35:27];
      s7_era_ff <= s6_era_ff;
      s7_hh_ff  <= s6_hh_ff;
      s7_mm_ff  <= s6_mm_ff;
      s7_ss_ff  <= s6_ss_ff;
      s7_err_ff <= s6_err_ff;

      s8_doy_ff   <= doy_full[8:0];
      s8_ybase_ff <= 14'(s7_yoe_ff) + 14'(s7_era_ff) * YEARS_PER_ERA;
      s8_hh_ff    <= s7_hh_ff;
      s8_mm_ff    <= s7_mm_ff;
      s8_ss_ff    <= s7_ss_ff;
      s8_err_ff   <= s7_err_ff;

      s9_year_ff  <= s8_ybase_ff + 14'(mp >= 4'd10);
      s9_day_ff   <= day_full[4:0];
      s9_month_ff <= (mp < 4'd10) ? 4'(mp + 4'd2) : 4'(mp - 4'd10);
      s9_hh_ff    <= s8_hh_ff;
      s9_mm_ff    <= s8_mm_ff;
      s9_ss_ff    <= s8_ss_ff;
      s9_err_ff   <= s8_err_ff;

      s10_year_ff  <= s9_year_ff;
      s10_cent_ff  <= cent_prod[27:21];
      s10_day_ff   <= s9_day_ff;
      s10_month_ff <= s9_month_ff;
      s10_hh_ff    <= s9_hh_ff;
      s10_mm_ff    <= s9_mm_ff;
      s10_ss_ff    <= s9_ss_ff;
      s10_err_ff   <= s9_err_ff;

      s11_cent_ff  <= s10_cent_ff;
      s11_yy_ff    <= yy_full[6:0];
      s11_day_ff   <= s10_day_ff;
      s11_month_ff <= s10_month_ff;
      s11_hh_ff    <= s10_hh_ff;
      s11_mm_ff    <= s10_mm_ff;
      s11_ss_ff    <= s10_ss_ff;
      s11_err_ff   <= s10_err_ff;

      s12_entry_ff.range_err <= s11_err_ff;
      s12_entry_ff.day_tens  <= day_dig[5:4];
      s12_entry_ff.day_ones  <= day_dig[3:0];
      s12_entry_ff.month     <= s11_month_ff;
      s12_entry_ff.cent_tens <= cent_dig[7:4];
      s12_entry_ff.cent_ones <= cent_dig[3:0];
      s12_entry_ff.yr_tens   <= yy_dig[7:4];
      s12_entry_ff.yr_ones   <= yy_dig[3:0];
      s12_entry_ff.hr_tens   <= hh_dig[7:4];
      s12_entry_ff.hr_ones   <= hh_dig[3:0];
      s12_entry_ff.min_tens  <= mm_dig[7:4];
      s12_entry_ff.min_ones  <= mm_dig[3:0];
      s12_entry_ff.sec_tens  <= ss_dig[7:4];
      s12_entry_ff.sec_ones  <= ss_dig[3:0];
   end

   assign push_valid = vld_ff[NUM_STAGES-1];
   assign push_entry = s12_entry_ff;

endmodule

FILE: rtl/core/e2r_queue.sv
module e2r_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  e2r_pkg::e2r_entry_type push_entry,
   input  logic                   pop,
   output logic                   empty,
   output e2r_pkg::e2r_entry_type head_entry
);
   import e2r_pkg::*;

   e2r_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QIDX_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QIDX_W'(rd_ptr_ff + 1'b1);
         end
         count_ff <= QCNT_W'(count_ff + QCNT_W'(push) - QCNT_W'(pop));
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/e2r_back.sv
module e2r_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  e2r_pkg::e2r_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_text_char,
   output logic                   rsp_last_char,
   output logic                   rsp_range_error
);
   import e2r_pkg::*;

   // character positions in the text
   localparam logic [4:0] POS_DAY_TENS  = 5'd0;
   localparam logic [4:0] POS_DAY_ONES  = 5'd1;
   localparam logic [4:0] POS_SP_DAY    = 5'd2;
   localparam logic [4:0] POS_MON_A     = 5'd3;
   localparam logic [4:0] POS_MON_B     = 5'd4;
   localparam logic [4:0] POS_MON_C     = 5'd5;
   localparam logic [4:0] POS_SP_MON    = 5'd6;
   localparam logic [4:0] POS_CENT_TENS = 5'd7;
   localparam logic [4:0] POS_CENT_ONES = 5'd8;
   localparam logic [4:0] POS_YR_TENS   = 5'd9;
   localparam logic [4:0] POS_YR_ONES   = 5'd10;
   localparam logic [4:0] POS_SP_YR     = 5'd11;
   localparam logic [4:0] POS_HR_TENS   = 5'd12;
   localparam logic [4:0] POS_HR_ONES   = 5'd13;
   localparam logic [4:0] POS_COLON_HR  = 5'd14;
   localparam logic [4:0] POS_MIN_TENS  = 5'd15;
   localparam logic [4:0] POS_MIN_ONES  = 5'd16;
   localparam logic [4:0] POS_COLON_MIN = 5'd17;
   localparam logic [4:0] POS_SEC_TENS  = 5'd18;
   localparam logic [4:0] POS_SEC_ONES  = 5'd19;
   localparam logic [4:0] POS_SP_SEC    = 5'd20;
   localparam logic [4:0] POS_PLUS      = 5'd21;
   localparam logic [4:0] POS_ZONE_A    = 5'd22;
   localparam logic [4:0] POS_ZONE_B    = 5'd23;
   localparam logic [4:0] POS_ZONE_C    = 5'd24;
   localparam logic [4:0] POS_LAST      = 5'd25;

   e2r_entry_type     cur_ff;
   logic              cur_vld_ff, cur_vld_in;
   logic [4:0]        pos_ff, pos_in;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;

   logic              advance;
   logic              is_last;
   logic [CHAR_W-1:0] next_char;

   assign advance = cur_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_last = cur_ff.range_err || (pos_ff == POS_LAST);
   assign pop     = !empty && (!cur_vld_ff || (advance && is_last));

   // character for the current position
   always_comb begin
      unique case (pos_ff) inside
         POS_DAY_TENS:  next_char = digit_char({2'b00, cur_ff.day_tens});
         POS_DAY_ONES:  next_char = digit_char(cur_ff.day_ones);
         POS_MON_A:     next_char = month_char(cur_ff.month, 2'd0);
         POS_MON_B:     next_char = month_char(cur_ff.month, 2'd1);
         POS_MON_C:     next_char = month_char(cur_ff.month, 2'd2);
         POS_CENT_TENS: next_char = digit_char(cur_ff.cent_tens);
         POS_CENT_ONES: next_char = digit_char(cur_ff.cent_ones);
         POS_YR_TENS:   next_char = digit_char(cur_ff.yr_tens);
         POS_YR_ONES:   next_char = digit_char(cur_ff.yr_ones);
         POS_HR_TENS:   next_char = digit_char(cur_ff.hr_tens);
         POS_HR_ONES:   next_char = digit_char(cur_ff.hr_ones);
         POS_MIN_TENS:  next_char = digit_char(cur_ff.min_tens);
         POS_MIN_ONES:  next_char = digit_char(cur_ff.min_ones);
         POS_SEC_TENS:  next_char = digit_char(cur_ff.sec_tens);
         POS_SEC_ONES:  next_char = digit_char(cur_ff.sec_ones);
         POS_COLON_HR, POS_COLON_MIN: next_char = CH_COLON;
         POS_PLUS:      next_char = CH_PLUS;
         POS_ZONE_A, POS_ZONE_B, POS_ZONE_C, POS_LAST: next_char = CH_ZERO;
         POS_SP_DAY, POS_SP_MON, POS_SP_YR, POS_SP_SEC: next_char = CH_SPACE;
         default:       next_char = CH_SPACE;
      endcase
   end

   // current request and position
   always_comb begin
      cur_vld_in = cur_vld_ff;
      pos_in     = pos_ff;
      if (pop) begin
         cur_vld_in = 1'b1;
         pos_in     = (head_entry.day_tens == 2'd0) ? POS_DAY_ONES : POS_DAY_TENS;
      end else if (advance) begin
         cur_vld_in = !is_last;
         pos_in     = 5'(pos_ff + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (pop) begin
         cur_ff <= head_entry;
      end
      if (advance) begin
         rsp_char_ff <= cur_ff.range_err ? CH_NUL : next_char;
         rsp_last_ff <= is_last;
         rsp_err_ff  <= cur_ff.range_err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_char   = rsp_char_ff;
   assign rsp_last_char   = rsp_last_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

FILE: rtl/core/epoch_to_rfc2822_date_text_unit.sv
// Unix seconds to "D Mon YYYY HH:MM:SS +0000" text, one ASCII character per
// response.
// req channel: req_valid / req_stall with req_unix_seconds, taken at an edge
// where req_valid is high and req_stall low.
// rsp channel: rsp_valid / rsp_stall with rsp_text_char, rsp_last_char and
// rsp_range_error. rsp_last_char marks the final character of a request.
// A time past the end of year 9999 gives a single response with
// rsp_range_error and rsp_last_char set and a zero character.
// When idle, an accepted request passes the 12-stage conversion pipeline,
// the queue write, the serializer load and the output register before
// rsp_valid of its first character rises.
// Throughput: the output serializer sends one character per cycle while
// rsp_stall is low, so a request gives 25 or 26 characters (one for a range
// error); requests follow back to back while the queue has room.
// Reset clears all valid state and the queue; req_stall is high during reset.
// When the receiver stalls, the output register holds, the serializer waits,
// the queue fills; req_stall rises at four requests in pipeline and queue.
module epoch_to_rfc2822_date_text_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [37:0] req_unix_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_last_char,
   output logic        rsp_range_error
);
   import e2r_pkg::*;

   logic          push_valid;
   e2r_entry_type push_entry;
   logic          pop;
   logic          empty;
   e2r_entry_type head_entry;

   // conversion pipeline
   e2r_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_unix_seconds (req_unix_seconds),
      .pop              (pop),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // decoded dates waiting for output
   e2r_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .empty      (empty),
      .head_entry (head_entry)
   );

   // text serializer
   e2r_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_range_error (rsp_range_error)
   );

endmodule
